/* src/mlfq_pkg.sv */
// shared types and constants of the multilevel feedback queue slot scheduler
// used by mlfq_slot_scheduler_unit; no dependencies
package mlfq_pkg;

   localparam int MAX_PROCS   = 32;
   localparam int PROC_BITS   = $clog2(MAX_PROCS);
   localparam int CNT_BITS    = $clog2(MAX_PROCS + 1);
   localparam int MAX_LEVELS  = 3;
   localparam int LVL_BITS    = 2;
   localparam int TIME_BITS   = 16;
   localparam int PID_BITS    = 8;
   localparam int QMEM_DEPTH  = MAX_LEVELS * MAX_PROCS;
   localparam int QADDR_BITS  = $clog2(QMEM_DEPTH);
   localparam int CSR_BITS    = 3;
   localparam int CSR_DATA    = 16;
   localparam int DIV_CNT_BITS = $clog2(TIME_BITS);

   localparam logic [CSR_BITS-1:0] CSR_QUEUES = 3'd0;
   localparam logic [CSR_BITS-1:0] CSR_SLICE0 = 3'd1;
   localparam logic [CSR_BITS-1:0] CSR_SLICE1 = 3'd2;
   localparam logic [CSR_BITS-1:0] CSR_SLICE2 = 3'd3;
   localparam logic [CSR_BITS-1:0] CSR_ALLOT0 = 3'd4;
   localparam logic [CSR_BITS-1:0] CSR_ALLOT1 = 3'd5;
   localparam logic [CSR_BITS-1:0] CSR_ALLOT2 = 3'd6;
   localparam logic [CSR_BITS-1:0] CSR_BOOST  = 3'd7;

   localparam logic FUNC_LOAD     = 1'b0;
   localparam logic FUNC_DISPATCH = 1'b1;

   typedef struct packed {
      logic                 func;
      logic [PID_BITS-1:0]  proc_id;
      logic [TIME_BITS-1:0] arrive_at;
      logic [TIME_BITS-1:0] burst_len;
   } req_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] slot_begin;
      logic [TIME_BITS-1:0] slot_finish;
      logic [PID_BITS-1:0]  run_id;
      logic [TIME_BITS-1:0] run_arrival;
      logic [TIME_BITS-1:0] time_left;
      logic                 all_finished;
   } rsp_type;

   typedef struct packed {
      logic [PID_BITS-1:0]  pid;
      logic [TIME_BITS-1:0] arr;
      logic [TIME_BITS-1:0] burst;
   } ent_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] served;
      logic [TIME_BITS-1:0] nsl;
   } stat_type;

   typedef struct packed {
      logic [PID_BITS-1:0]  pid;
      logic [PROC_BITS-1:0] idx;
   } list_type;

   typedef enum logic [26:0] {
      S_IDLE      = 27'd1 << 0,
      S_START_RD  = 27'd1 << 1,
      S_START_SET = 27'd1 << 2,
      S_ADM_RD    = 27'd1 << 3,
      S_ADM_CHK   = 27'd1 << 4,
      S_ANY       = 27'd1 << 5,
      S_MIN_RD    = 27'd1 << 6,
      S_MIN_CHK   = 27'd1 << 7,
      S_MIN_SET   = 27'd1 << 8,
      S_POP       = 27'd1 << 9,
      S_POP_W     = 27'd1 << 10,
      S_ENT_USE   = 27'd1 << 11,
      S_DIV       = 27'd1 << 12,
      S_SLOT_A    = 27'd1 << 13,
      S_SLOT_B    = 27'd1 << 14,
      S_DEM       = 27'd1 << 15,
      S_REQ       = 27'd1 << 16,
      S_BST_CHK   = 27'd1 << 17,
      S_BC_SEL    = 27'd1 << 18,
      S_BC_Q      = 27'd1 << 19,
      S_BC_T      = 27'd1 << 20,
      S_LA_RD     = 27'd1 << 21,
      S_LA_CHK    = 27'd1 << 22,
      S_LB_RD     = 27'd1 << 23,
      S_LB_CHK    = 27'd1 << 24,
      S_LB_WR     = 27'd1 << 25,
      S_EMIT      = 27'd1 << 26
   } state_type;

endpackage

/* src/mlfq_slot_scheduler_unit.sv */
// multilevel feedback queue slot scheduler with periodic priority boost
// depends on mlfq_pkg (types, constants, state codes)
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | req_data  (mlfq_pkg::req_type)
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_data  (mlfq_pkg::rsp_type)
//  csr     | in        | csr_we                 | csr_index, csr_wdata
//
// a load request writes one table entry; a dispatch request runs an arrival scan over
//   the table entries (up to four scans), passes of the shared restoring divider
//   (two passes with boosting on), plus, on a boost, a drain of the queued processes and,
//   for each distinct pid, a search over the drained list and a pass that requeues
//   the processes with that pid
// the sequencer handles one request at a time; the table memory read port sets the pace
// synchronous active-high reset clears control state; memories need no clearing pass
// a finished result waits in the output register; the next request is taken meanwhile
module mlfq_slot_scheduler_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  mlfq_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output mlfq_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [mlfq_pkg::CSR_BITS-1:0]        csr_index,
   input  logic [mlfq_pkg::CSR_DATA-1:0]        csr_wdata
);

   localparam int NP  = mlfq_pkg::MAX_PROCS;
   localparam int PB  = mlfq_pkg::PROC_BITS;
   localparam int CB  = mlfq_pkg::CNT_BITS;
   localparam int NL  = mlfq_pkg::MAX_LEVELS;
   localparam int LB  = mlfq_pkg::LVL_BITS;
   localparam int TB  = mlfq_pkg::TIME_BITS;
   localparam int PDB = mlfq_pkg::PID_BITS;
   localparam int QAB = mlfq_pkg::QADDR_BITS;
   localparam int DCB = mlfq_pkg::DIV_CNT_BITS;

   // memories: process table, per-process stats, ready queues, boost list
   mlfq_pkg::ent_type  tab_mem   [NP];
   mlfq_pkg::stat_type st_mem    [NP];
   logic [PB-1:0]      q_mem     [mlfq_pkg::QMEM_DEPTH];
   mlfq_pkg::list_type list_mem  [NP];

   mlfq_pkg::ent_type  tab_rd_ff;
   mlfq_pkg::stat_type st_rd_ff;
   logic [PB-1:0]      q_rd_ff;
   mlfq_pkg::list_type l_rd_ff;

   logic               tab_we, tab_re, st_we, st_re, l_we, l_re;
   logic [PB-1:0]      tab_wa, tab_ra, st_wa, st_ra, l_wa, l_ra;
   mlfq_pkg::ent_type  tab_wd;
   mlfq_pkg::stat_type st_wd;
   mlfq_pkg::list_type l_wd;

   // queue access: at most one push or one pop per cycle
   logic               push_en, pop_en;
   logic [LB-1:0]      push_lv, pop_lv;
   logic [PB-1:0]      push_idx;
   logic [QAB-1:0]     q_wa, q_ra;
   logic [PB:0]        tail_sum;
   logic [PB-1:0]      tail_pos;

   // state and registers
   mlfq_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   logic [1:0]         qiu_ff, qiu_in;
   logic [TB-1:0]      slice_ff [NL];
   logic [TB-1:0]      slice_in [NL];
   logic [TB-1:0]      allot_ff [NL];
   logic [TB-1:0]      allot_in [NL];
   logic [TB-1:0]      bper_ff, bper_in;
   logic [CB-1:0]      pcount_ff, pcount_in, fcount_ff, fcount_in;
   logic               started_ff, started_in;
   logic [TB-1:0]      ctime_ff, ctime_in;
   logic [NP-1:0]      admitted_ff, admitted_in;
   logic [PB-1:0]      qhead_ff [NL];
   logic [PB-1:0]      qhead_in [NL];
   logic [CB-1:0]      qlen_ff [NL];
   logic [CB-1:0]      qlen_in [NL];
   logic [PB-1:0]      scan_ff, scan_in;
   logic [TB-1:0]      thr_ff, thr_in;
   logic               strict_ff, strict_in;
   logic               mfound_ff, mfound_in;
   logic [TB-1:0]      mval_ff, mval_in;
   logic [LB-1:0]      lv_ff, lv_in;
   logic [PB-1:0]      idx_ff, idx_in;
   mlfq_pkg::ent_type  ent_ff, ent_in;
   logic [TB-1:0]      served_ff, served_in, nsl_ff, nsl_in, start_ff, start_in;
   logic [TB-1:0]      drem_ff, drem_in, dquo_ff, dquo_in, dden_ff, dden_in;
   logic [DCB-1:0]     dcnt_ff, dcnt_in;
   logic               dsel_ff, dsel_in;
   logic [TB-1:0]      end1_ff, end1_in, end_ff, end_in;
   logic [TB:0]        p_ff, p_in;
   logic               hit_ff, hit_in, boost_ff, boost_in, demote_ff, demote_in;
   logic [TB-1:0]      servn_ff, servn_in, nsln_ff, nsln_in;
   logic [CB-1:0]      nl_ff, nl_in, em_ff, em_in;
   logic [PB-1:0]      lj_ff, lj_in;
   logic [PDB-1:0]     last_ff, last_in, mn_ff, mn_in;
   logic               first_ff, first_in, fnd_ff, fnd_in;
   mlfq_pkg::rsp_type  rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // combinational helpers
   logic [LB-1:0]      top_lv, hi_lv;
   logic               q_any;
   logic [TB-1:0]      slc, allot_sel;
   logic [TB:0]        div_t;
   logic               div_ge;
   logic [TB:0]        sum_end;
   logic [TB-1:0]      end0, remb, span, slot;
   logic [TB:0]        p_calc;
   logic               adm_hit, min_hit, la_cand;
   logic [TB-1:0]      quo_eff;
   logic [CB+1:0]      q_total;

   // top level index: zero levels act as one
   assign top_lv = (qiu_ff == 2'd0) ? LB'(0) :
                   ((32'(qiu_ff) > NL) ? LB'(NL - 1) : LB'(qiu_ff - 2'd1));

   always_comb begin
      hi_lv   = '0;
      q_any   = 1'b0;
      q_total = '0;
      for (int l = 0; l < NL; l++) begin
         if (qlen_ff[l] != '0) begin
            hi_lv = LB'(l);
            q_any = 1'b1;
         end
         q_total = q_total + (CB+2)'(qlen_ff[l]);
      end
   end

   // slice and allotment of the level being served
   assign slc       = (slice_ff[lv_ff] == '0) ? TB'(1) : slice_ff[lv_ff];
   assign allot_sel = allot_ff[lv_ff];

   // one restoring divider step
   assign div_t  = {drem_ff, dquo_ff[TB-1]};
   assign div_ge = div_t >= {1'b0, dden_ff};

   // slot bounds
   assign sum_end = {1'b0, start_ff} + {1'b0, slc};
   assign end0    = sum_end[TB] ? {TB{1'b1}} : sum_end[TB-1:0];
   assign p_calc  = {1'b0, start_ff} - {1'b0, drem_ff} + {1'b0, bper_ff};
   assign remb    = ent_ff.burst - served_ff;
   assign span    = end1_ff - start_ff;
   assign slot    = (remb < span) ? remb : span;
   assign quo_eff = (dquo_ff == '0) ? TB'(1) : dquo_ff;

   // arrival and boost compares
   assign adm_hit = !admitted_ff[scan_ff] &&
                    (strict_ff ? (tab_rd_ff.arr < thr_ff) : (tab_rd_ff.arr <= thr_ff));
   assign min_hit = !admitted_ff[scan_ff] && (!mfound_ff || tab_rd_ff.arr < mval_ff);
   assign la_cand = (first_ff || l_rd_ff.pid > last_ff) && (!fnd_ff || l_rd_ff.pid < mn_ff);

   // queue tail position
   assign tail_sum = {1'b0, qhead_ff[push_lv]} + (PB+1)'(qlen_ff[push_lv]);
   assign tail_pos = (32'(tail_sum) >= NP) ? PB'(32'(tail_sum) - NP) : tail_sum[PB-1:0];
   assign q_wa     = QAB'(32'(push_lv) * NP) + QAB'(tail_pos);
   assign q_ra     = QAB'(32'(pop_lv) * NP) + QAB'(qhead_ff[pop_lv]);

   assign req_stall = (state_ff != mlfq_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      qiu_in      = qiu_ff;
      slice_in    = slice_ff;
      allot_in    = allot_ff;
      bper_in     = bper_ff;
      pcount_in   = pcount_ff;
      fcount_in   = fcount_ff;
      started_in  = started_ff;
      ctime_in    = ctime_ff;
      admitted_in = admitted_ff;
      qhead_in    = qhead_ff;
      qlen_in     = qlen_ff;
      scan_in     = scan_ff;
      thr_in      = thr_ff;
      strict_in   = strict_ff;
      mfound_in   = mfound_ff;
      mval_in     = mval_ff;
      lv_in       = lv_ff;
      idx_in      = idx_ff;
      ent_in      = ent_ff;
      served_in   = served_ff;
      nsl_in      = nsl_ff;
      start_in    = start_ff;
      drem_in     = drem_ff;
      dquo_in     = dquo_ff;
      dden_in     = dden_ff;
      dcnt_in     = dcnt_ff;
      dsel_in     = dsel_ff;
      end1_in     = end1_ff;
      end_in      = end_ff;
      p_in        = p_ff;
      hit_in      = hit_ff;
      boost_in    = boost_ff;
      demote_in   = demote_ff;
      servn_in    = servn_ff;
      nsln_in     = nsln_ff;
      nl_in       = nl_ff;
      em_in       = em_ff;
      lj_in       = lj_ff;
      last_in     = last_ff;
      mn_in       = mn_ff;
      first_in    = first_ff;
      fnd_in      = fnd_ff;
      rsp_in      = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      tab_we = 1'b0; tab_wa = '0; tab_wd = '0; tab_re = 1'b0; tab_ra = '0;
      st_we  = 1'b0; st_wa  = '0; st_wd  = '0; st_re  = 1'b0; st_ra  = '0;
      l_we   = 1'b0; l_wa   = '0; l_wd   = '0; l_re   = 1'b0; l_ra   = '0;
      push_en = 1'b0; push_lv = '0; push_idx = '0;
      pop_en  = 1'b0; pop_lv  = '0;

      // register writes
      if (csr_we) begin
         case (csr_index)
            mlfq_pkg::CSR_QUEUES: qiu_in      = csr_wdata[1:0];
            mlfq_pkg::CSR_SLICE0: slice_in[0] = csr_wdata;
            mlfq_pkg::CSR_SLICE1: slice_in[1] = csr_wdata;
            mlfq_pkg::CSR_SLICE2: slice_in[2] = csr_wdata;
            mlfq_pkg::CSR_ALLOT0: allot_in[0] = csr_wdata;
            mlfq_pkg::CSR_ALLOT1: allot_in[1] = csr_wdata;
            mlfq_pkg::CSR_ALLOT2: allot_in[2] = csr_wdata;
            mlfq_pkg::CSR_BOOST:  bper_in     = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         mlfq_pkg::S_IDLE: begin
            if (req_valid) begin
               if (req_data.func == mlfq_pkg::FUNC_LOAD) begin
                  // a full table drops the load
                  if (32'(pcount_ff) < NP) begin
                     tab_we = 1'b1;
                     tab_wa = PB'(pcount_ff);
                     tab_wd = '{pid: req_data.proc_id, arr: req_data.arrive_at,
                                burst: req_data.burst_len};
                     st_we  = 1'b1;
                     st_wa  = PB'(pcount_ff);
                     st_wd  = '0;
                     admitted_in[PB'(pcount_ff)] = 1'b0;
                     pcount_in = pcount_ff + CB'(1);
                  end
               end else if (pcount_ff != '0 && fcount_ff < pcount_ff) begin
                  state_in = started_ff ? mlfq_pkg::S_ANY : mlfq_pkg::S_START_RD;
               end
            end
         end
         mlfq_pkg::S_START_RD: begin
            tab_re   = 1'b1;
            tab_ra   = '0;
            state_in = mlfq_pkg::S_START_SET;
         end
         mlfq_pkg::S_START_SET: begin
            // run starts at the first entry's arrival
            started_in = 1'b1;
            ctime_in   = tab_rd_ff.arr;
            thr_in     = tab_rd_ff.arr;
            strict_in  = 1'b0;
            scan_in    = '0;
            ret_in     = mlfq_pkg::S_ANY;
            state_in   = mlfq_pkg::S_ADM_RD;
         end
         mlfq_pkg::S_ADM_RD: begin
            tab_re   = 1'b1;
            tab_ra   = scan_ff;
            state_in = mlfq_pkg::S_ADM_CHK;
         end
         mlfq_pkg::S_ADM_CHK: begin
            if (adm_hit) begin
               admitted_in[scan_ff] = 1'b1;
               push_en  = 1'b1;
               push_lv  = top_lv;
               push_idx = scan_ff;
            end
            if (CB'(scan_ff) + CB'(1) >= pcount_ff) begin
               state_in = ret_ff;
            end else begin
               scan_in  = scan_ff + PB'(1);
               state_in = mlfq_pkg::S_ADM_RD;
            end
         end
         mlfq_pkg::S_ANY: begin
            if (q_any) begin
               state_in = mlfq_pkg::S_POP;
            end else begin
               mfound_in = 1'b0;
               scan_in   = '0;
               state_in  = mlfq_pkg::S_MIN_RD;
            end
         end
         mlfq_pkg::S_MIN_RD: begin
            tab_re   = 1'b1;
            tab_ra   = scan_ff;
            state_in = mlfq_pkg::S_MIN_CHK;
         end
         mlfq_pkg::S_MIN_CHK: begin
            if (min_hit) begin
               mfound_in = 1'b1;
               mval_in   = tab_rd_ff.arr;
            end
            if (CB'(scan_ff) + CB'(1) >= pcount_ff) begin
               state_in = mlfq_pkg::S_MIN_SET;
            end else begin
               scan_in  = scan_ff + PB'(1);
               state_in = mlfq_pkg::S_MIN_RD;
            end
         end
         mlfq_pkg::S_MIN_SET: begin
            // idle ready set: jump forward to the earliest pending arrival
            if (!mfound_ff) begin
               state_in = mlfq_pkg::S_IDLE;
            end else begin
               if (mval_ff > ctime_ff) begin
                  ctime_in = mval_ff;
               end
               thr_in    = (mval_ff > ctime_ff) ? mval_ff : ctime_ff;
               strict_in = 1'b0;
               scan_in   = '0;
               ret_in    = mlfq_pkg::S_POP;
               state_in  = mlfq_pkg::S_ADM_RD;
            end
         end
         mlfq_pkg::S_POP: begin
            pop_en   = 1'b1;
            pop_lv   = hi_lv;
            lv_in    = hi_lv;
            state_in = mlfq_pkg::S_POP_W;
         end
         mlfq_pkg::S_POP_W: begin
            idx_in   = q_rd_ff;
            tab_re   = 1'b1;
            tab_ra   = q_rd_ff;
            st_re    = 1'b1;
            st_ra    = q_rd_ff;
            state_in = mlfq_pkg::S_ENT_USE;
         end
         mlfq_pkg::S_ENT_USE: begin
            ent_in    = tab_rd_ff;
            served_in = st_rd_ff.served;
            nsl_in    = st_rd_ff.nsl;
            start_in  = ctime_ff;
            if (bper_ff != '0) begin
               // start / boost_period for the next boost point
               drem_in  = '0;
               dquo_in  = ctime_ff;
               dden_in  = bper_ff;
               dcnt_in  = '0;
               dsel_in  = 1'b0;
               state_in = mlfq_pkg::S_DIV;
            end else begin
               drem_in  = '0;
               state_in = mlfq_pkg::S_SLOT_A;
            end
         end
         mlfq_pkg::S_DIV: begin
            drem_in = div_ge ? TB'(div_t - {1'b0, dden_ff}) : div_t[TB-1:0];
            dquo_in = {dquo_ff[TB-2:0], div_ge};
            dcnt_in = dcnt_ff + DCB'(1);
            if (dcnt_ff == DCB'(TB - 1)) begin
               state_in = dsel_ff ? mlfq_pkg::S_DEM : mlfq_pkg::S_SLOT_A;
            end
         end
         mlfq_pkg::S_SLOT_A: begin
            p_in   = p_calc;
            hit_in = (bper_ff != '0) && (p_calc <= {1'b0, end0});
            end1_in = ((bper_ff != '0) && (p_calc <= {1'b0, end0})) ? p_calc[TB-1:0] : end0;
            state_in = mlfq_pkg::S_SLOT_B;
         end
         mlfq_pkg::S_SLOT_B: begin
            end_in   = start_ff + slot;
            servn_in = served_ff + slot;
            nsln_in  = (nsl_ff != {TB{1'b1}}) ? nsl_ff + TB'(1) : nsl_ff;
            boost_in = hit_ff && ({1'b0, start_ff + slot} == p_ff);
            // allotment / slice for the demotion count
            drem_in  = '0;
            dquo_in  = allot_sel;
            dden_in  = slc;
            dcnt_in  = '0;
            dsel_in  = 1'b1;
            state_in = mlfq_pkg::S_DIV;
         end
         mlfq_pkg::S_DEM: begin
            demote_in = nsln_ff >= quo_eff;
            thr_in    = end_ff;
            strict_in = 1'b1;
            scan_in   = '0;
            ret_in    = mlfq_pkg::S_REQ;
            state_in  = mlfq_pkg::S_ADM_RD;
         end
         mlfq_pkg::S_REQ: begin
            st_we = 1'b1;
            st_wa = idx_ff;
            st_wd = '{served: servn_ff, nsl: demote_ff ? TB'(0) : nsln_ff};
            if (servn_ff >= ent_ff.burst) begin
               fcount_in = fcount_ff + CB'(1);
            end else begin
               push_en  = 1'b1;
               push_idx = idx_ff;
               // demotion floors at the lowest level
               push_lv  = (demote_ff && lv_ff != '0) ? lv_ff - LB'(1) : lv_ff;
            end
            ctime_in  = end_ff;
            thr_in    = end_ff;
            strict_in = 1'b0;
            scan_in   = '0;
            ret_in    = mlfq_pkg::S_BST_CHK;
            state_in  = mlfq_pkg::S_ADM_RD;
         end
         mlfq_pkg::S_BST_CHK: begin
            if (boost_ff) begin
               nl_in    = '0;
               state_in = mlfq_pkg::S_BC_SEL;
            end else begin
               state_in = mlfq_pkg::S_EMIT;
            end
         end
         mlfq_pkg::S_BC_SEL: begin
            // drain all queues, top level first
            if (q_any) begin
               pop_en   = 1'b1;
               pop_lv   = hi_lv;
               state_in = mlfq_pkg::S_BC_Q;
            end else if (nl_ff == '0) begin
               state_in = mlfq_pkg::S_EMIT;
            end else begin
               first_in = 1'b1;
               fnd_in   = 1'b0;
               em_in    = '0;
               lj_in    = '0;
               state_in = mlfq_pkg::S_LA_RD;
            end
         end
         mlfq_pkg::S_BC_Q: begin
            tab_re   = 1'b1;
            tab_ra   = q_rd_ff;
            state_in = mlfq_pkg::S_BC_T;
         end
         mlfq_pkg::S_BC_T: begin
            l_we     = 1'b1;
            l_wa     = PB'(nl_ff);
            l_wd     = '{pid: tab_rd_ff.pid, idx: q_rd_ff};
            nl_in    = nl_ff + CB'(1);
            state_in = mlfq_pkg::S_BC_SEL;
         end
         mlfq_pkg::S_LA_RD: begin
            l_re     = 1'b1;
            l_ra     = lj_ff;
            state_in = mlfq_pkg::S_LA_CHK;
         end
         mlfq_pkg::S_LA_CHK: begin
            // smallest pid above the last one emitted
            if (la_cand) begin
               fnd_in = 1'b1;
               mn_in  = l_rd_ff.pid;
            end
            if (CB'(lj_ff) + CB'(1) >= nl_ff) begin
               lj_in    = '0;
               state_in = mlfq_pkg::S_LB_RD;
            end else begin
               lj_in    = lj_ff + PB'(1);
               state_in = mlfq_pkg::S_LA_RD;
            end
         end
         mlfq_pkg::S_LB_RD: begin
            l_re     = 1'b1;
            l_ra     = lj_ff;
            state_in = mlfq_pkg::S_LB_CHK;
         end
         mlfq_pkg::S_LB_CHK, mlfq_pkg::S_LB_WR: begin
            if (state_ff == mlfq_pkg::S_LB_CHK && l_rd_ff.pid == mn_ff) begin
               st_re    = 1'b1;
               st_ra    = l_rd_ff.idx;
               state_in = mlfq_pkg::S_LB_WR;
            end else begin
               if (state_ff == mlfq_pkg::S_LB_WR) begin
                  // requeue at the top in list order, slice count restarts
                  st_we    = 1'b1;
                  st_wa    = l_rd_ff.idx;
                  st_wd    = '{served: st_rd_ff.served, nsl: TB'(0)};
                  push_en  = 1'b1;
                  push_lv  = top_lv;
                  push_idx = l_rd_ff.idx;
                  em_in    = em_ff + CB'(1);
               end
               if (CB'(lj_ff) + CB'(1) >= nl_ff) begin
                  lj_in    = '0;
                  last_in  = mn_ff;
                  first_in = 1'b0;
                  fnd_in   = 1'b0;
                  if (em_in == nl_ff) begin
                     state_in = mlfq_pkg::S_EMIT;
                  end else begin
                     state_in = mlfq_pkg::S_LA_RD;
                  end
               end else begin
                  lj_in    = lj_ff + PB'(1);
                  state_in = mlfq_pkg::S_LB_RD;
               end
            end
         end
         mlfq_pkg::S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.slot_begin   = start_ff;
               rsp_in.slot_finish  = end_ff;
               rsp_in.run_id       = ent_ff.pid;
               rsp_in.run_arrival  = ent_ff.arr;
               rsp_in.time_left    = ent_ff.burst - servn_ff;
               rsp_in.all_finished = fcount_ff >= pcount_ff;
               rsp_valid_in = 1'b1;
               state_in     = mlfq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mlfq_pkg::S_IDLE;
         end
      endcase

      // queue pointer update
      if (push_en) begin
         qlen_in[push_lv] = qlen_ff[push_lv] + CB'(1);
      end
      if (pop_en) begin
         qlen_in[pop_lv]  = qlen_ff[pop_lv] - CB'(1);
         qhead_in[pop_lv] = (32'(qhead_ff[pop_lv]) == NP - 1) ? PB'(0)
                                                             : qhead_ff[pop_lv] + PB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlfq_pkg::S_IDLE;
         ret_ff       <= mlfq_pkg::S_IDLE;
         qiu_ff       <= 2'd3;
         slice_ff[0]  <= TB'(8);
         slice_ff[1]  <= TB'(4);
         slice_ff[2]  <= TB'(2);
         allot_ff[0]  <= TB'(16);
         allot_ff[1]  <= TB'(8);
         allot_ff[2]  <= TB'(4);
         bper_ff      <= TB'(100);
         pcount_ff    <= '0;
         fcount_ff    <= '0;
         started_ff   <= 1'b0;
         ctime_ff     <= '0;
         admitted_ff  <= '0;
         for (int l = 0; l < NL; l++) begin
            qhead_ff[l] <= '0;
            qlen_ff[l]  <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         qiu_ff       <= qiu_in;
         slice_ff     <= slice_in;
         allot_ff     <= allot_in;
         bper_ff      <= bper_in;
         pcount_ff    <= pcount_in;
         fcount_ff    <= fcount_in;
         started_ff   <= started_in;
         ctime_ff     <= ctime_in;
         admitted_ff  <= admitted_in;
         qhead_ff     <= qhead_in;
         qlen_ff      <= qlen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      thr_ff    <= thr_in;
      strict_ff <= strict_in;
      mfound_ff <= mfound_in;
      mval_ff   <= mval_in;
      lv_ff     <= lv_in;
      idx_ff    <= idx_in;
      ent_ff    <= ent_in;
      served_ff <= served_in;
      nsl_ff    <= nsl_in;
      start_ff  <= start_in;
      drem_ff   <= drem_in;
      dquo_ff   <= dquo_in;
      dden_ff   <= dden_in;
      dcnt_ff   <= dcnt_in;
      dsel_ff   <= dsel_in;
      end1_ff   <= end1_in;
      end_ff    <= end_in;
      p_ff      <= p_in;
      hit_ff    <= hit_in;
      boost_ff  <= boost_in;
      demote_ff <= demote_in;
      servn_ff  <= servn_in;
      nsln_ff   <= nsln_in;
      nl_ff     <= nl_in;
      em_ff     <= em_in;
      lj_ff     <= lj_in;
      last_ff   <= last_in;
      mn_ff     <= mn_in;
      first_ff  <= first_in;
      fnd_ff    <= fnd_in;
      rsp_ff    <= rsp_in;
   end

   // memories, registered read
   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_mem[tab_wa] <= tab_wd;
      end
      if (tab_re) begin
         tab_rd_ff <= tab_mem[tab_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[st_wa] <= st_wd;
      end
      if (st_re) begin
         st_rd_ff <= st_mem[st_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         q_mem[q_wa] <= push_idx;
      end
      if (pop_en) begin
         q_rd_ff <= q_mem[q_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (l_we) begin
         list_mem[l_wa] <= l_wd;
      end
      if (l_re) begin
         l_rd_ff <= list_mem[l_ra];
      end
   end

`ifndef SYNTHESIS
   // queued entries never outnumber loaded processes
   assert property (@(posedge clock) disable iff (reset)
      q_total <= (CB+2)'(pcount_ff))
      else $error("queued entries exceed loaded processes");

   // completions never outnumber loads
   assert property (@(posedge clock) disable iff (reset)
      fcount_ff <= pcount_ff)
      else $error("finished count exceeds process count");

   // a new result appears only from the emit step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == mlfq_pkg::S_EMIT))
      else $error("result raised outside emit");

   // a slot never ends before it starts
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == mlfq_pkg::S_EMIT) |-> (end_ff >= start_ff))
      else $error("slot end before slot start");
`endif

endmodule
